// ===== rtl/jbdu_pkg.sv =====
package jbdu_pkg;

    localparam int MAX_FACTOR      = 8;
    localparam int RANGE_ENTRIES   = 768;
    localparam int DEPTH_BITS      = 16;
    localparam int WEIGHT_BITS     = 16;
    localparam int SPATIAL_ENTRIES = 2 * MAX_FACTOR + 1;
    localparam int RANGE_AW        = $clog2(RANGE_ENTRIES);
    localparam int SPATIAL_AW      = $clog2(SPATIAL_ENTRIES);
    localparam int SCALE_W         = 4;
    localparam int DIST_W          = 10;
    localparam int SUM_W           = WEIGHT_BITS + 3;
    localparam int NUM_W           = WEIGHT_BITS + DEPTH_BITS + 4;

    localparam logic [1:0] KIND_RANGE   = 2'd0;
    localparam logic [1:0] KIND_SPATIAL = 2'd1;
    localparam logic [1:0] KIND_PIXEL   = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic CFG_SCALE_X = 1'b0;
    localparam logic CFG_SCALE_Y = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(2);

    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic [NUM_W-1:0]      num;
        logic [SUM_W-1:0]      sum;
        logic [DEPTH_BITS-1:0] d0;
    } t_div_in;

    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic [DEPTH_BITS-1:0] quot;
        logic [DEPTH_BITS-1:0] d0;
    } t_div_out;

    function automatic logic [DIST_W-1:0] color_dist(logic [23:0] a, logic [23:0] b);
        logic [7:0]        x;
        logic [7:0]        y;
        logic [DIST_W-1:0] s;
        s = '0;
        for (int c = 0; c < 3; c++) begin
            x = a[8*c +: 8];
            y = b[8*c +: 8];
            s = s + DIST_W'((x > y) ? (x - y) : (y - x));
        end
        return s;
    endfunction

    function automatic logic [SCALE_W-1:0] clamp_scale(logic [SCALE_W-1:0] s);
        if (s == '0) begin
            return SCALE_W'(1);
        end
        if (s > SCALE_W'(MAX_FACTOR)) begin
            return SCALE_W'(MAX_FACTOR);
        end
        return s;
    endfunction

endpackage

// ===== rtl/jbdu_ram.sv =====
module jbdu_ram #(
    parameter int DEPTH = 768,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/jbdu_div.sv =====
module jbdu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  jbdu_pkg::t_div_in i_op,
    output jbdu_pkg::t_div_out o_res
);

    typedef struct packed {
        logic                            valid;
        logic                            zero;
        logic [jbdu_pkg::NUM_W-1:0]      rem;
        logic [jbdu_pkg::SUM_W-1:0]      sum;
        logic [jbdu_pkg::DEPTH_BITS-1:0] quot;
        logic [jbdu_pkg::DEPTH_BITS-1:0] d0;
    } t_stage;

    t_stage r_st [jbdu_pkg::DEPTH_BITS];
    t_stage n_st [jbdu_pkg::DEPTH_BITS];

    // one quotient bit per stage, msb first
    always_comb begin
        t_stage                     s;
        logic [jbdu_pkg::NUM_W-1:0] dv;
        for (int i = 0; i < jbdu_pkg::DEPTH_BITS; i++) begin
            if (i == 0) begin
                s.valid = i_op.valid;
                s.zero  = i_op.zero;
                s.rem   = i_op.num;
                s.sum   = i_op.sum;
                s.quot  = '0;
                s.d0    = i_op.d0;
            end else begin
                s = r_st[i-1];
            end
            dv = jbdu_pkg::NUM_W'(s.sum) << (jbdu_pkg::DEPTH_BITS - 1 - i);
            if (s.rem >= dv) begin
                s.rem = s.rem - dv;
                s.quot[jbdu_pkg::DEPTH_BITS-1-i] = 1'b1;
            end
            n_st[i] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < jbdu_pkg::DEPTH_BITS; i++) begin
                r_st[i].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_res.valid = r_st[jbdu_pkg::DEPTH_BITS-1].valid;
    assign o_res.zero  = r_st[jbdu_pkg::DEPTH_BITS-1].zero;
    assign o_res.quot  = r_st[jbdu_pkg::DEPTH_BITS-1].quot;
    assign o_res.d0    = r_st[jbdu_pkg::DEPTH_BITS-1].d0;

endmodule

// ===== rtl/joint_bilateral_depth_upsample.sv =====
// Joint bilateral depth upsampler. Load the range table (kind 0, index = L1 RGB distance) and
// the spatial table (kind 1, index = Manhattan offset) before sending pixels (kind 2); table
// entries never loaded read as garbage and there is no clearing pass after reset. One
// transaction of any kind is taken per clock while the output is not stalled; a pixel result
// passes through the table read, two multiply stages, accumulate, a 16-stage divider pipeline
// with one quotient bit per stage and the output register. Load transactions give no result.
// The whole pipeline holds while the output transaction is stalled. The user must write the
// scale registers only while no pixel is in flight; the block itself does not enforce this.
module joint_bilateral_depth_upsample (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [3:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // table_entry, sub_position, center_color, top_left_color, top_right_color,
    // bottom_left_color, bottom_right_color, top_left_depth, top_right_depth,
    // bottom_left_depth, bottom_right_depth
    input  logic [223:0] s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // depth_out
    output logic [15:0]  m_axis_tdata,
    // zero_weight
    output logic [0:0]   m_axis_tuser
);

    localparam int W = jbdu_pkg::WEIGHT_BITS;
    localparam int D = jbdu_pkg::DEPTH_BITS;

    logic [jbdu_pkg::SCALE_W-1:0] r_scale_x;
    logic [jbdu_pkg::SCALE_W-1:0] r_scale_y;

    logic        w_en;
    logic        w_acc;
    logic [9:0]  w_idx;
    logic [3:0]  w_k;
    logic [3:0]  w_l;
    logic [3:0]  w_kk;
    logic [3:0]  w_ll;
    logic [jbdu_pkg::SCALE_W-1:0] w_sx;
    logic [jbdu_pkg::SCALE_W-1:0] w_sy;
    logic [jbdu_pkg::SPATIAL_AW-1:0] w_sp [4];
    logic [jbdu_pkg::DIST_W-1:0]     w_dist [4];
    logic [D-1:0] w_depth [4];
    logic        w_range_we;
    logic        w_spat_we;
    logic [W-1:0] w_rg [4];
    logic [W-1:0] w_sw [4];
    logic [2*W:0] w_rnd [4];

    logic          r_v1;
    logic [D-1:0]  r_d1 [4];
    logic          r_v2;
    logic [D-1:0]  r_d2 [4];
    logic [W:0]    r_w2 [4];
    logic          r_v3;
    logic [D-1:0]  r_d03;
    logic [W+D:0]  r_p3 [4];
    logic [jbdu_pkg::SUM_W-1:0] r_sum3;
    logic          r_v4;
    logic          r_zero4;
    logic [D-1:0]  r_d04;
    logic [jbdu_pkg::NUM_W-1:0] r_num4;
    logic [jbdu_pkg::SUM_W-1:0] r_sum4;
    logic          r_out_valid;
    logic [D-1:0]  r_out_depth;
    logic          r_out_zero;

    jbdu_pkg::t_div_in  w_div_in;
    jbdu_pkg::t_div_out w_div_out;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= jbdu_pkg::SCALE_RESET;
            r_scale_y <= jbdu_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                jbdu_pkg::CFG_SCALE_X: r_scale_x <= i_cfg_wdata;
                jbdu_pkg::CFG_SCALE_Y: r_scale_y <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_idx = s_axis_tdata[25:16];
    assign w_k   = s_axis_tdata[29:26];
    assign w_l   = s_axis_tdata[33:30];
    assign w_sx  = jbdu_pkg::clamp_scale(r_scale_x);
    assign w_sy  = jbdu_pkg::clamp_scale(r_scale_y);
    assign w_kk  = (w_k > w_sx - 4'd1) ? w_sx - 4'd1 : w_k;
    assign w_ll  = (w_l > w_sy - 4'd1) ? w_sy - 4'd1 : w_l;

    assign w_sp[0] = jbdu_pkg::SPATIAL_AW'({1'b0, w_kk} + {1'b0, w_ll});
    assign w_sp[1] = jbdu_pkg::SPATIAL_AW'({1'b0, w_sx} - {1'b0, w_kk} + {1'b0, w_ll});
    assign w_sp[2] = jbdu_pkg::SPATIAL_AW'({1'b0, w_kk} + {1'b0, w_sy} - {1'b0, w_ll});
    assign w_sp[3] = jbdu_pkg::SPATIAL_AW'({1'b0, w_sx} - {1'b0, w_kk}
                                           + {1'b0, w_sy} - {1'b0, w_ll});

    assign w_dist[0] = jbdu_pkg::color_dist(s_axis_tdata[57:34], s_axis_tdata[81:58]);
    assign w_dist[1] = jbdu_pkg::color_dist(s_axis_tdata[57:34], s_axis_tdata[105:82]);
    assign w_dist[2] = jbdu_pkg::color_dist(s_axis_tdata[57:34], s_axis_tdata[129:106]);
    assign w_dist[3] = jbdu_pkg::color_dist(s_axis_tdata[57:34], s_axis_tdata[153:130]);

    assign w_depth[0] = s_axis_tdata[154 +: D];
    assign w_depth[1] = s_axis_tdata[170 +: D];
    assign w_depth[2] = s_axis_tdata[186 +: D];
    assign w_depth[3] = s_axis_tdata[202 +: D];

    assign w_range_we = w_acc && (s_axis_tuser == jbdu_pkg::KIND_RANGE)
                        && ({1'b0, w_idx} < 11'(jbdu_pkg::RANGE_ENTRIES));
    assign w_spat_we  = w_acc && (s_axis_tuser == jbdu_pkg::KIND_SPATIAL)
                        && ({1'b0, w_idx} < 11'(jbdu_pkg::SPATIAL_ENTRIES));

    jbdu_ram #(.DEPTH(jbdu_pkg::RANGE_ENTRIES), .WIDTH(W)) u_range_a (
        .i_clk     (i_clk),
        .i_we      (w_range_we),
        .i_waddr   (jbdu_pkg::RANGE_AW'(w_idx)),
        .i_wdata   (s_axis_tdata[W-1:0]),
        .i_re      (w_en),
        .i_raddr_a (jbdu_pkg::RANGE_AW'(w_dist[0])),
        .i_raddr_b (jbdu_pkg::RANGE_AW'(w_dist[1])),
        .o_rdata_a (w_rg[0]),
        .o_rdata_b (w_rg[1])
    );

    jbdu_ram #(.DEPTH(jbdu_pkg::RANGE_ENTRIES), .WIDTH(W)) u_range_b (
        .i_clk     (i_clk),
        .i_we      (w_range_we),
        .i_waddr   (jbdu_pkg::RANGE_AW'(w_idx)),
        .i_wdata   (s_axis_tdata[W-1:0]),
        .i_re      (w_en),
        .i_raddr_a (jbdu_pkg::RANGE_AW'(w_dist[2])),
        .i_raddr_b (jbdu_pkg::RANGE_AW'(w_dist[3])),
        .o_rdata_a (w_rg[2]),
        .o_rdata_b (w_rg[3])
    );

    jbdu_ram #(.DEPTH(jbdu_pkg::SPATIAL_ENTRIES), .WIDTH(W)) u_spat_a (
        .i_clk     (i_clk),
        .i_we      (w_spat_we),
        .i_waddr   (jbdu_pkg::SPATIAL_AW'(w_idx)),
        .i_wdata   (s_axis_tdata[W-1:0]),
        .i_re      (w_en),
        .i_raddr_a (w_sp[0]),
        .i_raddr_b (w_sp[1]),
        .o_rdata_a (w_sw[0]),
        .o_rdata_b (w_sw[1])
    );

    jbdu_ram #(.DEPTH(jbdu_pkg::SPATIAL_ENTRIES), .WIDTH(W)) u_spat_b (
        .i_clk     (i_clk),
        .i_we      (w_spat_we),
        .i_waddr   (jbdu_pkg::SPATIAL_AW'(w_idx)),
        .i_wdata   (s_axis_tdata[W-1:0]),
        .i_re      (w_en),
        .i_raddr_a (w_sp[2]),
        .i_raddr_b (w_sp[3]),
        .o_rdata_a (w_sw[2]),
        .o_rdata_b (w_sw[3])
    );

    // corner weight, rounded q0.w
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_rnd[i] = (2*W+1)'(w_rg[i]) * (2*W+1)'(w_sw[i]) + ((2*W+1)'(1) << (W - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1    <= w_depth;
            r_d2    <= r_d1;
            r_d03   <= r_d2[0];
            r_d04   <= r_d03;
            for (int i = 0; i < 4; i++) begin
                r_w2[i] <= w_rnd[i][2*W:W];
                r_p3[i] <= r_w2[i] * r_d2[i];
            end
            r_sum3  <= jbdu_pkg::SUM_W'(r_w2[0]) + jbdu_pkg::SUM_W'(r_w2[1])
                       + jbdu_pkg::SUM_W'(r_w2[2]) + jbdu_pkg::SUM_W'(r_w2[3]);
            r_num4  <= jbdu_pkg::NUM_W'(r_p3[0]) + jbdu_pkg::NUM_W'(r_p3[1])
                       + jbdu_pkg::NUM_W'(r_p3[2]) + jbdu_pkg::NUM_W'(r_p3[3])
                       + jbdu_pkg::NUM_W'(r_sum3 >> 1);
            r_sum4  <= r_sum3;
            r_zero4 <= (r_sum3 == '0);
            r_out_depth <= w_div_out.zero ? w_div_out.d0 : w_div_out.quot;
            r_out_zero  <= w_div_out.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= w_acc && (s_axis_tuser == jbdu_pkg::KIND_PIXEL);
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= w_div_out.valid;
        end
    end

    assign w_div_in.valid = r_v4;
    assign w_div_in.zero  = r_zero4;
    assign w_div_in.num   = r_num4;
    assign w_div_in.sum   = r_sum4;
    assign w_div_in.d0    = r_d04;

    jbdu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_op    (w_div_in),
        .o_res   (w_div_out)
    );

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_depth;
    assign m_axis_tuser[0] = r_out_zero;

`ifndef ASSERT_OFF
    a_v1_from_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v1) |-> $past(w_acc && (s_axis_tuser == jbdu_pkg::KIND_PIXEL)))
        else $error("pipeline valid without pixel transaction");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_range_we || w_spat_we) |=> !r_v1)
        else $error("table load entered the pixel pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v4))
        else $error("pipeline moved while stalled");

    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_out.valid && w_en) |=> m_axis_tvalid)
        else $error("divider result lost");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]   kind;
        logic [223:0] data;
    } t_item;

    typedef struct {
        logic [15:0] depth;
        logic        zero;
    } t_depth_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_addr = 1'b0;
    logic [3:0]   i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [15:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    t_item        pending[$];
    t_depth_res   expected_depths[$];
    logic [15:0]  rng_tab [jbdu_pkg::RANGE_ENTRIES];
    logic [15:0]  spa_tab [jbdu_pkg::SPATIAL_ENTRIES];
    logic [3:0]   sc_x = 4'd2;
    logic [3:0]   sc_y = 4'd2;
    int           errors = 0;
    int           idle_cycles = 0;
    bit           quiet = 0;
    bit           long_go = 0;
    bit           long_done = 0;
    int           gap_left = 0;
    int           stall_left = 0;
    int           long_left = 0;

    joint_bilateral_depth_upsample dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [223:0] pack_pixel(logic [25:0] te, logic [7:0] sp,
            logic [23:0] cc, logic [23:0] c0, logic [23:0] c1, logic [23:0] c2,
            logic [23:0] c3, logic [15:0] d0, logic [15:0] d1, logic [15:0] d2,
            logic [15:0] d3);
        return {6'b0, d3, d2, d1, d0, c3, c2, c1, c0, cc, sp, te};
    endfunction

    function automatic logic [9:0] rgb_l1(logic [23:0] a, logic [23:0] b);
        logic [9:0] s;
        logic [7:0] x;
        logic [7:0] y;
        s = '0;
        for (int c = 0; c < 3; c++) begin
            x = a[8*c +: 8];
            y = b[8*c +: 8];
            s += (x > y) ? 10'(x - y) : 10'(y - x);
        end
        return s;
    endfunction

    function automatic logic [63:0] corner_w(int si, logic [9:0] ri);
        logic [63:0] p;
        p = 64'(spa_tab[si]) * 64'(rng_tab[ri]) + 64'd32768;
        return p >> 16;
    endfunction

    function automatic int eff_scale(logic [3:0] s);
        if (s == 0) return 1;
        if (s > jbdu_pkg::MAX_FACTOR) return jbdu_pkg::MAX_FACTOR;
        return int'(s);
    endfunction

    // updates the tables on loads, queues the expected depth on pixels
    task automatic predict_depth(logic [1:0] kind, logic [223:0] d);
        int          idx;
        int          sx;
        int          sy;
        int          k;
        int          l;
        logic [63:0] w [4];
        logic [63:0] sum;
        logic [63:0] num;
        logic [63:0] dep [4];
        t_depth_res  r;
        idx = int'(d[25:16]);
        if (kind == jbdu_pkg::KIND_RANGE) begin
            if (idx < jbdu_pkg::RANGE_ENTRIES) rng_tab[idx] = d[15:0];
        end else if (kind == jbdu_pkg::KIND_SPATIAL) begin
            if (idx < jbdu_pkg::SPATIAL_ENTRIES) spa_tab[idx] = d[15:0];
        end else if (kind == jbdu_pkg::KIND_PIXEL) begin
            sx = eff_scale(sc_x);
            sy = eff_scale(sc_y);
            k = int'(d[29:26]);
            l = int'(d[33:30]);
            if (k > sx - 1) k = sx - 1;
            if (l > sy - 1) l = sy - 1;
            for (int i = 0; i < 4; i++) dep[i] = 64'(d[154 + 16*i +: 16]);
            w[0] = corner_w(k + l, rgb_l1(d[57:34], d[81:58]));
            w[1] = corner_w(sx - k + l, rgb_l1(d[57:34], d[105:82]));
            w[2] = corner_w(k + sy - l, rgb_l1(d[57:34], d[129:106]));
            w[3] = corner_w(sx - k + sy - l, rgb_l1(d[57:34], d[153:130]));
            sum = w[0] + w[1] + w[2] + w[3];
            if (sum == 0) begin
                r.depth = dep[0][15:0];
                r.zero = 1'b1;
            end else begin
                num = w[0]*dep[0] + w[1]*dep[1] + w[2]*dep[2] + w[3]*dep[3];
                r.depth = 16'((num + (sum >> 1)) / sum);
                r.zero = 1'b0;
            end
            expected_depths.push_back(r);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_item it;
        logic  v;
        if (s_axis_tvalid && s_axis_tready) predict_depth(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && (!s_axis_tvalid || s_axis_tready)) begin
            v = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending.size() != 0) begin
                it = pending.pop_front();
                v = 1'b1;
                s_axis_tdata <= it.data;
                s_axis_tuser <= it.kind;
                if (!quiet && $urandom_range(15) == 0) gap_left = $urandom_range(1, 18);
            end
            s_axis_tvalid <= v;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_depth_res e;
        logic       r;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_depths.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result depth=%h zero=%b",
                    m_axis_tdata, m_axis_tuser);
            end else begin
                e = expected_depths.pop_front();
                if (e.depth !== m_axis_tdata || e.zero !== m_axis_tuser[0]) begin
                    errors++;
                    if (errors <= 10) $display("mismatch exp depth=%h zero=%b got depth=%h zero=%b",
                        e.depth, e.zero, m_axis_tdata, m_axis_tuser);
                end
            end
        end
        if (long_go && !long_done) begin
            long_done = 1;
            long_left = 300;
        end
        r = 1'b0;
        if (long_left > 0) begin
            long_left--;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            r = 1'b1;
            if (!quiet && $urandom_range(11) == 0) stall_left = $urandom_range(1, 18);
        end
        m_axis_tready <= i_rst_n ? r : 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= 5000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic push_load(logic [1:0] kind, logic [9:0] idx, logic [15:0] wt);
        t_item it;
        it.kind = kind;
        it.data = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it.data[223:218] = '0;
        it.data[25:0] = {idx, wt};
        pending.push_back(it);
    endtask

    task automatic push_pixel(logic [7:0] sp, logic [23:0] cc, logic [23:0] c0,
            logic [23:0] c1, logic [23:0] c2, logic [23:0] c3, logic [15:0] d0,
            logic [15:0] d1, logic [15:0] d2, logic [15:0] d3);
        t_item it;
        it.kind = jbdu_pkg::KIND_PIXEL;
        it.data = pack_pixel(26'($urandom), sp, cc, c0, c1, c2, c3, d0, d1, d2, d3);
        pending.push_back(it);
    endtask

    function automatic logic [23:0] near_color(logic [23:0] c);
        logic [23:0] r;
        if ($urandom_range(1) == 0) return 24'($urandom);
        for (int i = 0; i < 3; i++)
            r[8*i +: 8] = c[8*i +: 8] + 8'($urandom_range(0, 30)) - 8'd15;
        return r;
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_random(int n);
        int          sel;
        logic [23:0] cc;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            cc = 24'($urandom);
            if (sel < 84) begin
                push_pixel(8'($urandom), cc, near_color(cc), near_color(cc), near_color(cc),
                    near_color(cc), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
            end else if (sel < 91) begin
                push_load(jbdu_pkg::KIND_RANGE, 10'($urandom), rand_weight());
            end else if (sel < 97) begin
                push_load(jbdu_pkg::KIND_SPATIAL, ($urandom_range(1) == 0)
                    ? 10'($urandom_range(16)) : 10'($urandom), rand_weight());
            end else begin
                push_load(jbdu_pkg::KIND_NONE, 10'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending.size() != 0 || s_axis_tvalid || expected_depths.size() != 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_scales(logic [3:0] x, logic [3:0] y);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= jbdu_pkg::CFG_SCALE_X;
        i_cfg_wdata <= x;
        @(posedge i_clk);
        i_cfg_addr <= jbdu_pkg::CFG_SCALE_Y;
        i_cfg_wdata <= y;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sc_x = x;
        sc_y = y;
    endtask

    initial begin
        logic [3:0] xs [7];
        logic [3:0] ys [7];
        xs = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};
        ys = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd7, 4'd1, 4'd4};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < jbdu_pkg::RANGE_ENTRIES; i++)
            push_load(jbdu_pkg::KIND_RANGE, 10'(i), (i == 0) ? 16'hFFFF : 16'($urandom));
        for (int i = 0; i < jbdu_pkg::SPATIAL_ENTRIES; i++)
            push_load(jbdu_pkg::KIND_SPATIAL, 10'(i), 16'hFFFF);
        // extremes at the reset scale
        push_pixel(8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        push_pixel(8'h00, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        push_pixel(8'hFF, '0, '1, '1, '1, '1, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0);
        push_pixel(8'h11, 24'h00FF00, '1, '0, 24'hFF00FF, 24'h123456,
            16'h1234, 16'hFFFF, 16'h0001, 16'h8000);
        push_pixel(8'hF0, 24'h808080, 24'h808080, '0, '1, 24'h7F7F7F,
            16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // out of range indexes and the unused kind change nothing
        push_load(jbdu_pkg::KIND_RANGE, 10'd768, 16'h0);
        push_load(jbdu_pkg::KIND_RANGE, 10'h3FF, 16'h0);
        push_load(jbdu_pkg::KIND_SPATIAL, 10'd17, 16'h0);
        push_load(jbdu_pkg::KIND_SPATIAL, 10'h3FF, 16'h0);
        push_load(jbdu_pkg::KIND_NONE, 10'd0, 16'h0);
        push_pixel(8'h00, '0, '0, '0, '0, '0, 16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0);
        // all weights zero
        for (int i = 0; i < jbdu_pkg::SPATIAL_ENTRIES; i++)
            push_load(jbdu_pkg::KIND_SPATIAL, 10'(i), 16'h0);
        push_pixel(8'h01, '0, '1, '0, '1, '0, 16'hBEEF, 16'h1, 16'h2, 16'h3);
        push_pixel(8'h0F, 24'h00FF00, '0, '1, '0, '1, 16'hFFFF, 16'h1, 16'h2, 16'h3);
        for (int i = 0; i < jbdu_pkg::SPATIAL_ENTRIES; i++)
            push_load(jbdu_pkg::KIND_SPATIAL, 10'(i), 16'($urandom) | 16'h1);
        push_random(20);
        // long receiver hold once pixels are flowing
        wait (expected_depths.size() != 0);
        long_go = 1;
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            write_scales(xs[p], ys[p]);
            push_random(10);
            wait_idle();
        end
        write_scales(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)));
        quiet = 1;
        push_random(10);
        wait_idle();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
